// File: rtl/fnv1a_linear_probe_hash_table_defines.svh
// assertion macros used by the hash table module
`ifndef FNV1A_LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define FNV1A_LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// implication checked on every edge out of reset
`define FLPH_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FLPH_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/flph_pkg.sv
package flph_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    // handshake between the sequencer and the hash unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_hash_ctl;

endpackage

// File: rtl/flph_hash.sv
// fnv-1a over one key byte per step; the prime multiply is split as
// h*prime = h + (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1)
module flph_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_key,
    input  logic [3:0]          i_len,
    output flph_pkg::t_hash_ctl o_ctl,
    output logic [63:0]         o_hash
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_hash, n_hash;
    logic [63:0] r_key, n_key;
    logic [3:0]  r_left, n_left;
    logic [63:0] w_x;
    logic [63:0] w_mul;

    // one byte folded into the running hash
    assign w_x   = r_hash ^ {56'd0, r_key[7:0]};
    assign w_mul = w_x + (w_x << 40) + (w_x << 8) + (w_x << 7)
                 + (w_x << 5) + (w_x << 4) + (w_x << 1);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_hash = r_hash;
        n_key  = r_key;
        n_left = r_left;
        if (i_start) begin
            n_busy = 1'b1;
            n_hash = flph_pkg::FNV_BASIS;
            n_key  = i_key;
            n_left = i_len;
        end else if (r_busy) begin
            if (r_left == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_hash = w_mul;
                n_key  = r_key >> 8;
                n_left = r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_hash <= n_hash;
        r_key  <= n_key;
        r_left <= n_left;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_hash      = r_hash;

endmodule

// File: rtl/fnv1a_linear_probe_hash_table.sv
// Open-addressing hash table keyed by 64-bit FNV-1a with linear probing.
// One request at a time: s_axis_tready is high only while the block is idle.
// A request passes through the byte-serial hash unit (start, one step per key
// byte, done), then through a read state and a compare state per probed slot
// (registered memory read, then compare, with the insert write in the compare
// state), then holds its result until it is taken. A full-table insert
// presents its result the cycle after acceptance. After reset a clearing pass
// resets the valid marks of all CAPACITY slots, and no request is accepted
// during it. CAPACITY must be a power of two, since the low hash bits pick the
// home slot. Keys are compared on their first key_len bytes (saturated to
// KEY_BYTES). Inserts are refused once the table holds CAPACITY/2 entries.
`include "fnv1a_linear_probe_hash_table_defines.svh"
module fnv1a_linear_probe_hash_table #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // kind
    input  logic          s_axis_tuser,
    // key[63:0], key_len[67:64], value[131:68], zero fill
    input  logic [135:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[2:0], value_out[66:3], slot[76:67], zero fill
    output logic [79:0]   m_axis_tdata
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SLW  = 10;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_CMP, S_OUT
    } t_state;

    // slot memories
    logic                  r_valid_mem [CAPACITY];
    logic [63:0]           r_key_mem   [CAPACITY];
    logic [3:0]            r_len_mem   [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem   [CAPACITY];

    t_state                r_state;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic                  r_kind;
    logic [63:0]           r_key;
    logic [3:0]            r_len;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_rd_valid;
    logic [63:0]           r_rd_key;
    logic [3:0]            r_rd_len;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [2:0]            r_status;
    logic [63:0]           r_vout;
    logic [SLW-1:0]        r_slot;
    logic                  r_out_valid;
    logic                  r_hstart;

    flph_pkg::t_hash_ctl   w_hctl;
    logic [63:0]           w_hash;
    logic [3:0]            w_len;
    logic [63:0]           w_mask;
    logic [AW-1:0]         w_next_idx;
    logic                  w_hit;
    logic                  w_wr;
    logic [63:0]           w_vext;
    logic [SLW+AW-1:0]     w_slot_ext;

    // length saturation and byte mask of the incoming key
    assign w_len  = (s_axis_tdata[67:64] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                         : s_axis_tdata[67:64];
    assign w_mask = (w_len >= 4'd8) ? {64{1'b1}} : ((64'd1 << {w_len, 3'b000}) - 64'd1);

    assign w_next_idx = (r_idx == AW'(CAPACITY - 1)) ? '0 : r_idx + AW'(1);
    assign w_hit      = r_rd_valid && (r_rd_len == r_len) && (r_rd_key == r_key);
    assign w_wr       = (r_state == S_CMP) && !r_rd_valid && (r_kind == flph_pkg::KIND_INSERT);
    assign w_vext     = 64'(r_rd_val);
    assign w_slot_ext = (SLW+AW)'(r_idx);

    flph_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hstart),
        .i_key   (r_key),
        .i_len   (r_len),
        .o_ctl   (w_hctl),
        .o_hash  (w_hash)
    );

    // memory port: one write, one registered read at r_idx
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_valid_mem[r_idx] <= 1'b0;
        end else if (w_wr) begin
            r_valid_mem[r_idx] <= 1'b1;
            r_key_mem[r_idx]   <= r_key;
            r_len_mem[r_idx]   <= r_len;
            r_val_mem[r_idx]   <= r_value;
        end
        r_rd_valid <= r_valid_mem[r_idx];
        r_rd_key   <= r_key_mem[r_idx];
        r_rd_len   <= r_len_mem[r_idx];
        r_rd_val   <= r_val_mem[r_idx];
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hstart    <= 1'b0;
        end else begin
            r_hstart <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= w_next_idx;
                    if (r_idx == AW'(CAPACITY - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind  <= s_axis_tuser;
                        r_key   <= s_axis_tdata[63:0] & w_mask;
                        r_len   <= w_len;
                        r_value <= s_axis_tdata[68 +: VALUE_BITS];
                        r_vout  <= '0;
                        if (s_axis_tuser == flph_pkg::KIND_INSERT
                            && r_count >= CW'(CAPACITY / 2)) begin
                            r_status    <= flph_pkg::ST_FULL;
                            r_slot      <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_hstart <= 1'b1;
                            r_state  <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hctl.done) begin
                        r_idx   <= w_hash[AW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    if (!r_rd_valid || w_hit) begin
                        r_slot      <= w_slot_ext[SLW-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                        if (r_kind == flph_pkg::KIND_INSERT) begin
                            r_status <= w_hit ? flph_pkg::ST_DUPLICATE
                                              : flph_pkg::ST_INSERTED;
                            if (!w_hit) r_count <= r_count + CW'(1);
                        end else begin
                            r_status <= w_hit ? flph_pkg::ST_FOUND : flph_pkg::ST_MISSING;
                            if (w_hit) r_vout <= w_vext;
                        end
                    end else begin
                        r_idx   <= w_next_idx;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_slot, r_vout, r_status};

    `FLPH_ASSERT_IMP(a_out_state, i_clk, i_rst_n, r_out_valid, r_state == S_OUT,
        "result valid outside output state")
    `FLPH_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY / 2),
        "entry count above half capacity")
    `FLPH_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, r_hstart, w_hctl.busy,
        "hash unit did not start")
    `FLPH_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready,
        !r_out_valid && !w_hctl.busy, "ready while a request is in flight")

endmodule

// File: tb/sv/fnv1a_linear_probe_hash_table_test.sv
`timescale 1ns / 1ps
module fnv1a_linear_probe_hash_table_test;

    localparam int SLOTS = 1024;
    localparam int LIMIT = 3000000;

    // packed to match the result tdata layout, lowest field last
    typedef struct packed {
        logic [9:0]  slot;
        logic [63:0] value_out;
        logic [2:0]  status;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic         s_axis_tuser;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;

    // shadow copy of the table
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key [SLOTS];
    logic [3:0]  tbl_len [SLOTS];
    logic [63:0] tbl_value [SLOTS];
    int          tbl_count;

    t_answer answers_due [$];
    logic [63:0] known_keys [$];
    logic [3:0]  known_lens [$];
    int  errors = 0;
    int  answers_seen = 0;
    int  items_sent;
    int  cycles = 0;
    int  send_gap_pct;
    int  recv_stall_pct;

    fnv1a_linear_probe_hash_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] fnv_hash(logic [63:0] key, int len);
        logic [63:0] h;
        h = flph_pkg::FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            h = h ^ {56'd0, key[i*8 +: 8]};
            h = h * flph_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    // table lookup and update for one request
    function automatic t_answer table_apply(logic kind, logic [63:0] key_in,
                                            logic [3:0] len_in, logic [63:0] val);
        t_answer a;
        int len;
        int idx;
        logic [63:0] key;
        logic hit;
        len = (len_in > 8) ? 8 : len_in;
        key = (len == 8) ? key_in : key_in & ((64'd1 << (len * 8)) - 64'd1);
        a = '0;
        if (kind == flph_pkg::KIND_INSERT && tbl_count >= SLOTS / 2) begin
            a.status = flph_pkg::ST_FULL;
            return a;
        end
        idx = fnv_hash(key, len) % SLOTS;
        hit = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tbl_valid[idx]) break;
            if (tbl_len[idx] == len && tbl_key[idx] == key) begin
                hit = 1'b1;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        a.slot = idx[9:0];
        if (kind == flph_pkg::KIND_INSERT) begin
            if (hit) a.status = flph_pkg::ST_DUPLICATE;
            else begin
                tbl_valid[idx] = 1'b1;
                tbl_key[idx] = key;
                tbl_len[idx] = len[3:0];
                tbl_value[idx] = val;
                tbl_count++;
                a.status = flph_pkg::ST_INSERTED;
            end
        end else if (hit) begin
            a.status = flph_pkg::ST_FOUND;
            a.value_out = tbl_value[idx];
        end else begin
            a.status = flph_pkg::ST_MISSING;
        end
        return a;
    endfunction

    task automatic send_request(logic kind, logic [63:0] key, logic [3:0] len,
                                logic [63:0] val);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, val, len, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answers_due.push_back(table_apply(kind, key, len, val));
        items_sent++;
        if (kind == flph_pkg::KIND_INSERT) begin
            known_keys.push_back(key);
            known_lens.push_back(len);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[76:0];
                answers_seen++;
                if (answers_due.size() == 0) begin
                    $error("result with none expected: %h", got);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.value_out !== want.value_out) begin
                        $error("value_out expected %h actual %h",
                               want.value_out, got.value_out);
                        errors++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot expected %0d actual %0d", want.slot, got.slot);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(int gap, int stall);
        send_gap_pct = gap;
        recv_stall_pct = stall;
    endtask

    // random or reused key, lengths mostly 0 to 8 bytes, sometimes over-long
    task automatic random_request(int insert_pct);
        logic [63:0] key;
        logic [3:0] len;
        int pick;
        key = {$urandom, $urandom};
        len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        if (known_keys.size() != 0 && $urandom_range(99) < 40) begin
            pick = $urandom_range(known_keys.size() - 1);
            key = known_keys[pick];
            len = known_lens[pick];
            if ($urandom_range(3) == 0) key = key ^ ({$urandom, $urandom} << 8 * len);
        end
        send_request($urandom_range(99) < insert_pct ? flph_pkg::KIND_INSERT
                                                     : flph_pkg::KIND_FETCH,
                     key, len, {$urandom, $urandom});
    endtask

    // extremes and special cases
    task automatic test_directed();
        set_idling(0, 0);
        send_request(flph_pkg::KIND_FETCH, 64'd0, 4'd0, 64'd0);
        send_request(flph_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                     64'hFFFF_FFFF_FFFF_FFFF);
        send_request(flph_pkg::KIND_FETCH, 64'h1234, 4'd0, 64'd0);
        send_request(flph_pkg::KIND_INSERT, 64'd5, 4'd0, 64'd1);
        send_request(flph_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'd0);
        send_request(flph_pkg::KIND_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                     64'hFFFF_FFFF_FFFF_FFFF);
        send_request(flph_pkg::KIND_INSERT, 64'hAAAA_5555_AAAA_5555, 4'd12,
                     64'h5555_AAAA_5555_AAAA);
        send_request(flph_pkg::KIND_FETCH, 64'hAAAA_5555_AAAA_5555, 4'd8, 64'd0);
        send_request(flph_pkg::KIND_INSERT, 64'hDEAD_BEEF_0000_0041, 4'd1, 64'h77);
        send_request(flph_pkg::KIND_FETCH, 64'h0000_0000_0000_0041, 4'd1, 64'd0);
        send_request(flph_pkg::KIND_FETCH, 64'h0000_0000_0000_0041, 4'd2, 64'd0);
        send_request(flph_pkg::KIND_INSERT, 64'h0123_4567_89AB_CDEF, 4'd7, 64'h1);
        send_request(flph_pkg::KIND_FETCH, 64'hFF23_4567_89AB_CDEF, 4'd7, 64'd0);
        send_request(flph_pkg::KIND_FETCH, 64'h0123_4567_89AB_CDEF, 4'd8, 64'd0);
        drain();
    endtask

    // random traffic under the given idling pattern
    task automatic test_random(int count, int gap, int stall);
        set_idling(gap, stall);
        repeat (count) random_request(50);
        drain();
    endtask

    // fill to half capacity with fresh keys, then refused inserts and fetches
    task automatic test_full_table();
        set_idling(0, 0);
        while (tbl_count < SLOTS / 2)
            send_request(flph_pkg::KIND_INSERT, {$urandom, $urandom}, 4'd8,
                         {$urandom, $urandom});
        set_idling(25, 25);
        repeat (60) random_request(50);
        drain();
    endtask

    initial begin
        items_sent = 0;
        tbl_count = 0;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        set_idling(0, 0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(70, 0, 0);
        test_random(70, 82, 0);
        test_random(70, 0, 82);
        test_random(70, 25, 25);
        test_full_table();
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked, %0d entries at end",
                 items_sent, answers_seen, tbl_count);
        $display("inserts, duplicates, fetches, misses and full-table refusals");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/flph_pkg.sv
rtl/flph_hash.sv
rtl/fnv1a_linear_probe_hash_table.sv
tb/sv/fnv1a_linear_probe_hash_table_test.sv
